// ----- sv/silu_pkg.sv -----
// Shared types and constants for the sorted interval list update unit.
`timescale 1ns / 1ps
`default_nettype none
package silu_pkg;

    localparam int unsigned ADDR_W     = 16;
    localparam int unsigned SRC_W      = 32;
    localparam int unsigned DIRTY_W    = 5;
    localparam int unsigned DIRTY_CAP  = 24;
    localparam int unsigned TILE_SHIFT = 4;      // 0x10 bytes per tile
    localparam int unsigned BANK_TILES = 'h180;
    localparam logic [ADDR_W-1:0] BASE_RESET = 16'h8000;

    // One stored transfer record.
    typedef struct packed {
        logic [SRC_W-1:0]  src;
        logic [ADDR_W-1:0] len;
        logic [ADDR_W-1:0] dest;
    } t_entry;

endpackage
`default_nettype wire

// ----- sv/silu_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module silu_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 48
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

// ----- sv/sorted_interval_list_update_unit.sv -----
// Top level: per-bank sorted interval lists with dirty record generation.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//   Pulse i_start with the request fields while o_busy is low; the request is
//   taken on that edge and o_busy rises. The sequencer then walks the bank's
//   list from the scan cursor through a single RAM port pair, reading each
//   entry and then comparing or copying it. Removing or inserting entries
//   moves the list tail one entry at a time.
//   One request is in flight at a time; o_busy drops after the last step.
//   A dirty record, when produced, sits on o_tile_number, o_byte_count and
//   o_dirty_source for exactly one cycle with o_strobe high, in the same cycle
//   that o_busy first reads low. The receiver cannot stall; it must take it then.
//   i_cfg_we writes base_address; only write it while o_busy is low.
//   Reset (synchronous, active low) empties both lists, clears the scan
//   cursor and dirty count and restores base_address to 0x8000. No clearing
//   pass is needed: only entries below a list's count are ever read.
module sorted_interval_list_update_unit #(
    parameter int unsigned LIST_DEPTH = 24
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [silu_pkg::ADDR_W-1:0]    i_cfg_data,
    input  wire logic                           i_start,
    output logic                                o_busy,
    input  wire logic                           i_batch_start,
    input  wire logic                           i_bank,
    input  wire logic [silu_pkg::ADDR_W-1:0]    i_dest,
    input  wire logic [silu_pkg::ADDR_W-1:0]    i_length,
    input  wire logic [silu_pkg::SRC_W-1:0]     i_source,
    output logic                                o_strobe,
    output logic [silu_pkg::ADDR_W-1:0]         o_tile_number,
    output logic [silu_pkg::ADDR_W-1:0]         o_byte_count,
    output logic [silu_pkg::SRC_W-1:0]          o_dirty_source
);

    import silu_pkg::*;

    localparam int unsigned CW  = $clog2(LIST_DEPTH + 1);
    localparam int unsigned AW  = $clog2(2 * LIST_DEPTH);
    localparam int unsigned EW  = $bits(t_entry);
    localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SCAN    = 4'd1;
    localparam logic [3:0] S_CMP     = 4'd2;
    localparam logic [3:0] S_OVL_RD  = 4'd3;
    localparam logic [3:0] S_OVL_CMP = 4'd4;
    localparam logic [3:0] S_DEL_RD  = 4'd5;
    localparam logic [3:0] S_DEL_WR  = 4'd6;
    localparam logic [3:0] S_INS_RD  = 4'd7;
    localparam logic [3:0] S_INS_WR  = 4'd8;
    localparam logic [3:0] S_WR_NEW  = 4'd9;
    localparam logic [3:0] S_DONE    = 4'd10;

    logic [3:0]         r_state;
    logic [ADDR_W-1:0]  r_base;
    logic               r_bank;
    logic [ADDR_W-1:0]  r_dest;
    logic [ADDR_W-1:0]  r_len;
    logic [SRC_W-1:0]   r_src;
    logic [ADDR_W:0]    r_dl;       // dest + length, 17 bits
    logic [ADDR_W:0]    r_diff;     // dest - base, signed
    logic [CW-1:0]      r_i;
    logic [CW-1:0]      r_k;
    logic [CW-1:0]      r_gone;
    logic [CW-1:0]      r_cnt;
    logic [CW-1:0]      r_cursor;
    logic [CW-1:0]      r_counts [2];
    logic [DIRTY_W-1:0] r_dirty;
    logic               r_emit;
    logic               r_strobe;
    logic [ADDR_W-1:0]  r_tile;
    logic [ADDR_W-1:0]  r_bytes;
    logic [SRC_W-1:0]   r_dsrc;

    logic               rd_en;
    logic [CW-1:0]      rd_idx;
    logic               wr_en;
    logic [CW-1:0]      wr_idx;
    t_entry             wr_data;
    t_entry             rd_data;
    logic [EW-1:0]      rd_raw;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      bank_off;
    t_entry             rec;

    logic [ADDR_W:0]    oend;
    logic               hit;
    logic               ovl;
    logic               past;
    logic [CW:0]        jg;
    logic               jg_lt;
    logic [ADDR_W:0]    adj;
    logic [ADDR_W:0]    quot;
    logic [ADDR_W-1:0]  tile;

    assign rec      = '{src: r_src, len: r_len, dest: r_dest};
    assign rd_data  = t_entry'(rd_raw);
    assign bank_off = r_bank ? AW'(LIST_DEPTH) : '0;
    assign rd_addr  = AW'(rd_idx) + bank_off;
    assign wr_addr  = AW'(wr_idx) + bank_off;

    // Shared compare unit: stored entry against the held request.
    assign oend  = {1'b0, rd_data.dest} + {1'b0, rd_data.len};
    assign hit   = (rd_data.dest == r_dest) && (rd_data.len == r_len);
    assign ovl   = (r_dl > {1'b0, rd_data.dest}) && ({1'b0, r_dest} < oend);
    assign past  = {1'b0, r_dest} >= oend;
    assign jg    = {1'b0, r_k} + {1'b0, r_gone};
    assign jg_lt = jg < {1'b0, r_cnt};

    // Signed divide by 16 truncating toward zero, then bank offset.
    assign adj  = r_diff + (r_diff[ADDR_W] ? (ADDR_W + 1)'(15) : '0);
    assign quot = $signed(adj) >>> TILE_SHIFT;
    assign tile = quot[ADDR_W-1:0] + (r_bank ? ADDR_W'(BANK_TILES) : '0);

    always_comb begin
        rd_en   = 1'b0;
        rd_idx  = r_i;
        wr_en   = 1'b0;
        wr_idx  = r_i;
        wr_data = rec;
        unique case (r_state)
            S_SCAN: begin
                if (r_i < r_cnt) begin
                    rd_en = 1'b1;
                end else if (r_cnt < DEPTH_C) begin
                    wr_en  = 1'b1;
                    wr_idx = r_cnt;
                end
            end
            S_CMP: begin
                wr_en = hit && (rd_data.src != r_src);
            end
            S_OVL_RD: begin
                rd_en  = r_k < r_cnt;
                rd_idx = r_k;
            end
            S_DEL_RD: begin
                rd_en  = jg_lt;
                rd_idx = jg[CW-1:0];
            end
            S_DEL_WR, S_INS_WR: begin
                wr_en   = 1'b1;
                wr_idx  = r_k;
                wr_data = rd_data;
            end
            S_INS_RD: begin
                rd_en  = r_k > r_i;
                rd_idx = r_k - CW'(1);
            end
            S_WR_NEW: begin
                wr_en = 1'b1;
            end
            default: begin
            end
        endcase
    end

    silu_ram #(
        .WIDTH (EW),
        .DEPTH (2 * LIST_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_raw)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_base      <= BASE_RESET;
            r_cursor    <= '0;
            r_counts[0] <= '0;
            r_counts[1] <= '0;
            r_dirty     <= '0;
            r_emit      <= 1'b0;
            r_strobe    <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            if (i_cfg_we) begin
                r_base <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_bank <= i_bank;
                        r_dest <= i_dest;
                        r_len  <= i_length;
                        r_src  <= i_source;
                        r_dl   <= {1'b0, i_dest} + {1'b0, i_length};
                        r_diff <= {1'b0, i_dest} - {1'b0, r_base};
                        r_cnt  <= r_counts[i_bank];
                        r_emit <= 1'b0;
                        if (i_batch_start) begin
                            r_cursor <= '0;
                            r_dirty  <= '0;
                            r_i      <= '0;
                        end else begin
                            r_i <= r_cursor;
                        end
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_i < r_cnt) begin
                        r_state <= S_CMP;
                    end else begin
                        // append at the tail; dropped when the list is full
                        if (r_cnt < DEPTH_C) begin
                            r_cnt  <= r_cnt + CW'(1);
                            r_emit <= 1'b1;
                        end
                        r_state <= S_DONE;
                    end
                end
                S_CMP: begin
                    priority if (hit) begin
                        r_cursor <= r_i + CW'(1);
                        r_emit   <= rd_data.src != r_src;
                        r_state  <= S_DONE;
                    end else if (ovl) begin
                        r_k     <= r_i + CW'(1);
                        r_state <= S_OVL_RD;
                    end else if (past) begin
                        r_i      <= r_i + CW'(1);
                        r_cursor <= r_i + CW'(1);
                        r_state  <= S_SCAN;
                    end else if (r_cnt < DEPTH_C) begin
                        r_k     <= r_cnt;
                        r_state <= S_INS_RD;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_OVL_RD: begin
                    if (r_k < r_cnt) begin
                        r_state <= S_OVL_CMP;
                    end else begin
                        r_gone  <= r_k - r_i - CW'(1);
                        r_k     <= r_i + CW'(1);
                        r_state <= S_DEL_RD;
                    end
                end
                S_OVL_CMP: begin
                    if (ovl) begin
                        r_k     <= r_k + CW'(1);
                        r_state <= S_OVL_RD;
                    end else begin
                        r_gone  <= r_k - r_i - CW'(1);
                        r_k     <= r_i + CW'(1);
                        r_state <= S_DEL_RD;
                    end
                end
                S_DEL_RD: begin
                    if (jg_lt) begin
                        r_state <= S_DEL_WR;
                    end else begin
                        r_cnt   <= r_cnt - r_gone;
                        r_state <= S_WR_NEW;
                    end
                end
                S_DEL_WR: begin
                    r_k     <= r_k + CW'(1);
                    r_state <= S_DEL_RD;
                end
                S_INS_RD: begin
                    if (r_k > r_i) begin
                        r_state <= S_INS_WR;
                    end else begin
                        r_cnt   <= r_cnt + CW'(1);
                        r_state <= S_WR_NEW;
                    end
                end
                S_INS_WR: begin
                    r_k     <= r_k - CW'(1);
                    r_state <= S_INS_RD;
                end
                S_WR_NEW: begin
                    r_emit   <= 1'b1;
                    r_cursor <= r_i + CW'(1);
                    r_state  <= S_DONE;
                end
                S_DONE: begin
                    r_counts[r_bank] <= r_cnt;
                    if (r_emit && (r_dirty < DIRTY_W'(DIRTY_CAP))) begin
                        r_strobe <= 1'b1;
                        r_dirty  <= r_dirty + DIRTY_W'(1);
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // dirty record payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE) begin
            r_tile  <= tile;
            r_bytes <= r_len;
            r_dsrc  <= r_src;
        end
    end

    assign o_busy         = r_state != S_IDLE;
    assign o_strobe       = r_strobe;
    assign o_tile_number  = r_tile;
    assign o_byte_count   = r_bytes;
    assign o_dirty_source = r_dsrc;

endmodule
`default_nettype wire

// ----- tb/dirty_record_checker.sv -----
// Checker for the sorted interval list update unit: tracks both bank lists, predicts dirty records.
`timescale 1ns / 1ps
`default_nettype none
module dirty_record_checker #(
    parameter int unsigned LIST_DEPTH = 24
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [silu_pkg::ADDR_W-1:0]    i_cfg_data,
    input  wire logic                           i_start,
    input  wire logic                           i_busy,
    input  wire logic                           i_batch_start,
    input  wire logic                           i_bank,
    input  wire logic [silu_pkg::ADDR_W-1:0]    i_dest,
    input  wire logic [silu_pkg::ADDR_W-1:0]    i_length,
    input  wire logic [silu_pkg::SRC_W-1:0]     i_source,
    input  wire logic                           i_strobe,
    input  wire logic [silu_pkg::ADDR_W-1:0]    i_tile_number,
    input  wire logic [silu_pkg::ADDR_W-1:0]    i_byte_count,
    input  wire logic [silu_pkg::SRC_W-1:0]     i_dirty_source,
    output int                                  o_fail_count,
    output int                                  o_pending,
    output int                                  o_checked
);

    localparam int TILE_BYTES   = 1 << silu_pkg::TILE_SHIFT;
    localparam int BANK_OFS     = int'(silu_pkg::BANK_TILES);
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [silu_pkg::ADDR_W-1:0] tile;
        logic [silu_pkg::ADDR_W-1:0] bytes;
        logic [silu_pkg::SRC_W-1:0]  src;
    } t_dirty_rec;

    silu_pkg::t_entry            entry_list [2][LIST_DEPTH];
    int unsigned                 entry_count [2];
    int unsigned                 scan_cursor;
    int unsigned                 dirty_emitted;
    logic [silu_pkg::ADDR_W-1:0] base_addr;
    t_dirty_rec                  pending_dirty [$];

    function automatic bit overlaps_entry(input bit bk, input int unsigned k,
                                          input int d, input int l);
        int od;
        int oend;
        od   = int'(entry_list[bk][k].dest);
        oend = od + int'(entry_list[bk][k].len);
        return (d + l > od) && (d < oend);
    endfunction

    // Merges one request into its bank list; returns 1 when a dirty record goes out.
    function automatic bit merge_record(input bit batch, input bit bk,
                                        input logic [silu_pkg::ADDR_W-1:0] d,
                                        input logic [silu_pkg::ADDR_W-1:0] l,
                                        input logic [silu_pkg::SRC_W-1:0] s,
                                        output t_dirty_rec rec);
        int unsigned cnt;
        int unsigned i;
        int unsigned k;
        int unsigned j;
        int unsigned gone;
        int dv;
        int lv;
        int od;
        int ol;
        int bv;
        int diff;
        int tile;
        bit emit;
        bit handled;
        emit    = 1'b0;
        handled = 1'b0;
        dv      = int'(d);
        lv      = int'(l);
        rec     = '0;
        if (batch) begin
            scan_cursor   = 0;
            dirty_emitted = 0;
        end
        cnt = entry_count[bk];
        for (i = scan_cursor; i < cnt && !handled; i++) begin
            od = int'(entry_list[bk][i].dest);
            ol = int'(entry_list[bk][i].len);
            if (od == dv && ol == lv) begin
                scan_cursor = i + 1;
                if (entry_list[bk][i].src != s) begin
                    entry_list[bk][i].src = s;
                    emit = 1'b1;
                end
                handled = 1'b1;
            end else if (overlaps_entry(bk, i, dv, lv)) begin
                // replace this entry and drop the overlapped ones right after it
                k = i + 1;
                while (k < cnt && overlaps_entry(bk, k, dv, lv))
                    k++;
                gone = k - (i + 1);
                for (j = i + 1; j + gone < cnt; j++)
                    entry_list[bk][j] = entry_list[bk][j + gone];
                cnt -= gone;
                entry_list[bk][i] = '{src: s, len: l, dest: d};
                emit        = 1'b1;
                scan_cursor = i + 1;
                handled     = 1'b1;
            end else if (dv >= od + ol) begin
                scan_cursor = i + 1;
            end else begin
                // full list: insert is dropped, cursor stays
                if (cnt < LIST_DEPTH) begin
                    for (j = cnt; j > i; j--)
                        entry_list[bk][j] = entry_list[bk][j - 1];
                    entry_list[bk][i] = '{src: s, len: l, dest: d};
                    cnt++;
                    emit        = 1'b1;
                    scan_cursor = i + 1;
                end
                handled = 1'b1;
            end
        end
        if (!handled && cnt < LIST_DEPTH) begin
            entry_list[bk][cnt] = '{src: s, len: l, dest: d};
            cnt++;
            emit = 1'b1;
        end
        entry_count[bk] = cnt;
        if (emit && dirty_emitted < silu_pkg::DIRTY_CAP) begin
            bv   = int'(base_addr);
            diff = dv - bv;
            // signed division truncates toward zero
            tile = diff / TILE_BYTES + (bk ? BANK_OFS : 0);
            rec.tile  = tile[15:0];
            rec.bytes = l;
            rec.src   = s;
            dirty_emitted++;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        o_fail_count++;
        if (o_fail_count <= REPORT_LIMIT)
            $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
    endtask

    always @(posedge i_clk) begin : watch
        t_dirty_rec want;
        t_dirty_rec fresh;
        if (!i_rst_n) begin
            entry_count[0] = 0;
            entry_count[1] = 0;
            scan_cursor    = 0;
            dirty_emitted  = 0;
            base_addr      = silu_pkg::BASE_RESET;
            pending_dirty.delete();
        end else begin
            if (i_strobe) begin
                if (pending_dirty.size() == 0) begin
                    flag_mismatch("unrequested dirty record (tile)", 32'h0,
                                  32'(i_tile_number));
                end else begin
                    want = pending_dirty.pop_front();
                    o_checked++;
                    if (want.tile !== i_tile_number)
                        flag_mismatch("tile_number", 32'(want.tile), 32'(i_tile_number));
                    if (want.bytes !== i_byte_count)
                        flag_mismatch("byte_count", 32'(want.bytes), 32'(i_byte_count));
                    if (want.src !== i_dirty_source)
                        flag_mismatch("dirty_source", want.src, i_dirty_source);
                end
            end
            if (i_cfg_we)
                base_addr = i_cfg_data;
            if (i_start && !i_busy) begin
                if (merge_record(i_batch_start, i_bank, i_dest, i_length, i_source, fresh))
                    pending_dirty.push_back(fresh);
            end
        end
        o_pending <= pending_dirty.size();
    end

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Top of the testbench: clock, reset, request stimulus, base writes and the verdict.
`timescale 1ns / 1ps
`default_nettype none
module testbench;

    localparam int unsigned LIST_DEPTH    = 24;
    localparam int          SETTLE_CYCLES = 4 * LIST_DEPTH + 16;
    localparam int          STALL_LIMIT   = 3000;
    localparam int          PHASE_ITEMS   = 285;
    localparam int          CALM_ITEMS    = 150;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [silu_pkg::ADDR_W-1:0]   i_cfg_data;
    logic                          i_start;
    logic                          o_busy;
    logic                          i_batch_start;
    logic                          i_bank;
    logic [silu_pkg::ADDR_W-1:0]   i_dest;
    logic [silu_pkg::ADDR_W-1:0]   i_length;
    logic [silu_pkg::SRC_W-1:0]    i_source;
    logic                          o_strobe;
    logic [silu_pkg::ADDR_W-1:0]   o_tile_number;
    logic [silu_pkg::ADDR_W-1:0]   o_byte_count;
    logic [silu_pkg::SRC_W-1:0]    o_dirty_source;

    int                            mismatches;
    int                            o_pending;
    int                            records_checked;
    int                            requests_sent;
    int                            base_writes;
    int                            stall_cycles;
    bit                            gaps_on;
    logic [silu_pkg::ADDR_W-1:0]   base_now;
    logic [silu_pkg::SRC_W-1:0]    src_pool [4];

    sorted_interval_list_update_unit #(
        .LIST_DEPTH (LIST_DEPTH)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_batch_start  (i_batch_start),
        .i_bank         (i_bank),
        .i_dest         (i_dest),
        .i_length       (i_length),
        .i_source       (i_source),
        .o_strobe       (o_strobe),
        .o_tile_number  (o_tile_number),
        .o_byte_count   (o_byte_count),
        .o_dirty_source (o_dirty_source)
    );

    dirty_record_checker #(
        .LIST_DEPTH (LIST_DEPTH)
    ) i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_start        (i_start),
        .i_busy         (o_busy),
        .i_batch_start  (i_batch_start),
        .i_bank         (i_bank),
        .i_dest         (i_dest),
        .i_length       (i_length),
        .i_source       (i_source),
        .i_strobe       (o_strobe),
        .i_tile_number  (o_tile_number),
        .i_byte_count   (o_byte_count),
        .i_dirty_source (o_dirty_source),
        .o_fail_count   (mismatches),
        .o_pending      (o_pending),
        .o_checked      (records_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // watchdog: cycles in a row with no request, result or write taken
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_strobe || i_cfg_we)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("testbench: errors");
            $finish;
        end
    end

    // Holds the request until the block takes it, then maybe idles a few cycles.
    task automatic send_record(input bit batch, input bit bk,
                               input logic [silu_pkg::ADDR_W-1:0] d,
                               input logic [silu_pkg::ADDR_W-1:0] l,
                               input logic [silu_pkg::SRC_W-1:0] s);
        i_start       <= 1'b1;
        i_batch_start <= batch;
        i_bank        <= bk;
        i_dest        <= d;
        i_length      <= l;
        i_source      <= s;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        requests_sent++;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    // Wait for every expected record, then cover requests that give none.
    task automatic settle();
        i_start <= 1'b0;
        do @(posedge i_clk); while (o_pending != 0 || o_busy !== 1'b0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_base(input logic [silu_pkg::ADDR_W-1:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        base_now = v;
        base_writes++;
    endtask

    // Mostly batches of ascending records on a 32-byte grid near the base,
    // so lists fill, hit equal entries and overlap; the rest is noise.
    task automatic run_phase(input int n_items);
        int          sent;
        int          burst;
        int          k;
        int unsigned slot;
        bit          bk;
        logic [silu_pkg::ADDR_W-1:0] d;
        logic [silu_pkg::ADDR_W-1:0] l;
        logic [silu_pkg::SRC_W-1:0]  s;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) < 2) begin
                d = 16'($urandom);
                l = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 96));
                send_record(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), d, l,
                            $urandom);
                sent++;
                if ($urandom_range(0, 7) == 0)
                    src_pool[$urandom_range(0, 3)] = $urandom;
            end else begin
                burst = $urandom_range(2, 36);
                bk    = 1'($urandom_range(0, 1));
                slot  = $urandom_range(0, 4);
                for (k = 0; k < burst && sent < n_items; k++) begin
                    if ($urandom_range(0, 19) == 0)
                        bk = ~bk;   // bank switch mid-batch
                    d = base_now + 16'(slot * 32);
                    if ($urandom_range(0, 7) == 0)
                        d = d + 16'($urandom_range(1, 31));
                    case ($urandom_range(0, 7))
                        4:       l = 16'd16;
                        5:       l = 16'd64;
                        6:       l = 16'd0;
                        7:       l = 16'($urandom_range(1, 200));
                        default: l = 16'd32;
                    endcase
                    s = ($urandom_range(0, 9) < 6) ? src_pool[$urandom_range(0, 3)] : $urandom;
                    send_record(k == 0, bk, d, l, s);
                    sent++;
                    slot += $urandom_range(0, 3);
                    if (slot > 47)
                        slot = $urandom_range(0, 4);
                end
            end
        end
    endtask

    initial begin
        int p;
        requests_sent = 0;
        base_writes   = 0;
        gaps_on       = 1'b1;
        base_now      = silu_pkg::BASE_RESET;
        for (p = 0; p < 4; p++)
            src_pool[p] = $urandom;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_data    <= '0;
        i_start       <= 1'b0;
        i_batch_start <= 1'b0;
        i_bank        <= 1'b0;
        i_dest        <= '0;
        i_length      <= '0;
        i_source      <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: base left at its reset value
        send_record(1'b1, 1'b0, 16'h8000, 16'h0010, 32'h1111_1111);  // append
        send_record(1'b1, 1'b0, 16'h8000, 16'h0010, 32'h1111_1111);  // identical, no record
        send_record(1'b1, 1'b0, 16'h8000, 16'h0010, 32'h2222_2222);  // source update
        send_record(1'b0, 1'b0, 16'h8100, 16'h0020, 32'h3333_3333);  // append at tail
        send_record(1'b1, 1'b0, 16'h8040, 16'h0010, 32'h4444_4444);  // insert in the middle
        send_record(1'b1, 1'b0, 16'h8008, 16'h0100, 32'h5555_5555);  // replace, drop two
        send_record(1'b0, 1'b1, 16'h8000, 16'h0030, 32'h6666_6666);  // cursor past empty bank
        send_record(1'b1, 1'b0, 16'h8200, 16'h0000, 32'h7777_7777);  // zero length
        send_record(1'b1, 1'b0, 16'h8200, 16'h0000, 32'h7777_7777);
        send_record(1'b0, 1'b1, 16'h0000, 16'h0005, 32'h8888_8888);  // dest zero, negative tile
        send_record(1'b0, 1'b1, 16'h7fe1, 16'h0010, 32'h9999_9999);  // truncation toward zero
        send_record(1'b1, 1'b1, 16'hffff, 16'hffff, 32'hffff_ffff);  // widest sums
        send_record(1'b0, 1'b0, 16'h0001, 16'h0000, 32'h0000_0000);
        send_record(1'b1, 1'b1, 16'h0001, 16'hffff, 32'h0f0f_0f0f);  // swallows whole list
        send_record(1'b0, 1'b1, 16'h8000, 16'h0001, 32'ha5a5_a5a5);

        for (p = 0; p < 4; p++) begin
            settle();
            case (p)
                0:       write_base(16'h0000);
                1:       write_base(16'hffff);
                2:       write_base(16'($urandom_range(0, 65535)));
                default: write_base(silu_pkg::BASE_RESET);
            endcase
            if (p < 3) begin
                run_phase(PHASE_ITEMS);
            end else begin
                run_phase(PHASE_ITEMS - CALM_ITEMS);
                gaps_on = 1'b0;
                run_phase(CALM_ITEMS);
            end
        end
        settle();

        $display("run covered %0d requests, %0d dirty records checked, %0d base writes",
                 requests_sent, records_checked, base_writes);
        if (o_pending != 0)
            $display("%0d expected dirty records never arrived", o_pending);
        if (mismatches == 0 && o_pending == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
`default_nettype wire
